/* hdl/utf8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
package utf8sd_pkg;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] MASK_E0     = 8'he0;
	localparam logic [7:0] LEAD2_CODE  = 8'hc0;
	localparam logic [7:0] MASK_F0     = 8'hf0;
	localparam logic [7:0] MASK_F8     = 8'hf8;
	localparam logic [7:0] LEAD3_CODE  = 8'he0;
	localparam logic [7:0] LEAD4_CODE  = 8'hf0;
	localparam logic [7:0] LEAD4_MAX   = 8'hf4;
	localparam logic [20:0] SURR_LO    = 21'h00d800;
	localparam logic [20:0] SURR_HI    = 21'h00dfff;

	localparam int MAX_RES = 3;

	// one result item
	typedef struct packed {
		logic [20:0] char_value;
		logic        valid_res;
		logic [2:0]  consumed;
		logic        run_last;
	} res_t;

	// all results caused by one input item
	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [1:0]         count;
	} group_t;

	// decoder sequence state
	typedef struct packed {
		logic [2:0][7:0] held;
		logic [1:0]      held_count;
		logic [2:0]      seq_len;
	} state_t;

endpackage

/* hdl/utf8sd_byte_if.sv */
// Input channel: one text byte per item with an end-of-text flag.
interface utf8sd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

/* hdl/utf8sd_cp_if.sv */
// Output channel: one decoded character result per item.
interface utf8sd_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] char_value;
	logic        valid_res;
	logic [2:0]  consumed;
	logic        run_last;

	modport source (output valid, output char_value, output valid_res, output consumed,
		output run_last, input ready);
	modport sink   (input valid, input char_value, input valid_res, input consumed,
		input run_last, output ready);
endinterface

/* hdl/utf8sd_decode.sv */
// Combinational byte decode: results and next sequence state for one byte.
module utf8sd_decode import utf8sd_pkg::*; (
	input  state_t     st,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output group_t     grp,
	output state_t     st_next
);

	function automatic logic [2:0] lead_class(input logic [7:0] b);
		logic [2:0] r;
		if (b < ASCII_LIMIT) begin
			r = 3'd1;
		end else if ((b & MASK_E0) == LEAD2_CODE) begin
			r = 3'd2;
		end else if ((b & MASK_F0) == LEAD3_CODE) begin
			r = 3'd3;
		end else if ((b & MASK_F8) == LEAD4_CODE && b <= LEAD4_MAX) begin
			r = 3'd4;
		end else begin
			r = 3'd0;
		end
		return r;
	endfunction

	function automatic res_t decoded(input logic [3:0][7:0] w, input logic [2:0] len);
		logic [20:0] v;
		logic        sur;
		res_t        r;
		unique case (len)
			3'd1: v = {13'd0, w[0]};
			3'd2: v = {10'd0, w[0][4:0], w[1][5:0]};
			3'd3: v = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
			3'd4: v = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
			default: v = '0;
		endcase
		sur = (v >= SURR_LO) && (v <= SURR_HI);
		r.char_value = sur ? '0 : v;
		r.valid_res  = ~sur;
		r.consumed   = len;
		r.run_last   = 1'b0;
		return r;
	endfunction

	function automatic res_t invalid_lead();
		res_t r;
		r.char_value = '0;
		r.valid_res  = 1'b0;
		r.consumed   = 3'd1;
		r.run_last   = 1'b0;
		return r;
	endfunction

	always_comb begin
		logic [3:0][7:0] seq_b;
		logic [3:0][7:0] win;
		logic [1:0]      cnt;
		logic [2:0]      n;
		logic [2:0]      pos;
		logic [2:0]      len;
		logic [2:0]      idx;
		logic [1:0]      k;

		cnt = (st.seq_len != 3'd0) ? st.held_count : 2'd0;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < cnt) begin
				seq_b[i] = st.held[i];
			end else if (2'(i) == cnt) begin
				seq_b[i] = in_byte;
			end else begin
				seq_b[i] = '0;
			end
		end
		seq_b[3] = (cnt == 2'd3) ? in_byte : 8'd0;
		n = {1'b0, cnt} + 3'd1;

		grp     = '0;
		st_next = st;
		k       = '0;
		pos     = '0;
		win     = '0;
		len     = '0;
		idx     = '0;

		if (end_of_text) begin
			// drain held bytes plus this one, restarting after a cut-short lead
			for (int s = 0; s < MAX_RES; s++) begin
				if (pos < n) begin
					for (int j = 0; j < 4; j++) begin
						idx = pos + 3'(j);
						win[j] = (idx < 3'd4) ? seq_b[idx[1:0]] : 8'd0;
					end
					len = lead_class(win[0]);
					if (len != 3'd0 && (n - pos) >= len) begin
						grp.res[k] = decoded(win, len);
						pos = pos + len;
					end else begin
						grp.res[k] = invalid_lead();
						pos = pos + 3'd1;
					end
					k = k + 2'd1;
				end
			end
			grp.count = k;
			st_next   = '0;
		end else if (st.seq_len == 3'd0) begin
			len = lead_class(in_byte);
			if (len == 3'd0) begin
				grp.res[0] = invalid_lead();
				grp.count  = 2'd1;
			end else if (len == 3'd1) begin
				grp.res[0] = decoded(seq_b, 3'd1);
				grp.count  = 2'd1;
			end else begin
				st_next.held[0]    = in_byte;
				st_next.held_count = 2'd1;
				st_next.seq_len    = len;
			end
		end else begin
			if (n >= st.seq_len || cnt == 2'd3) begin
				grp.res[0]         = decoded(seq_b, n);
				grp.count          = 2'd1;
				st_next.held_count = 2'd0;
				st_next.seq_len    = 3'd0;
			end else begin
				st_next.held[cnt]  = in_byte;
				st_next.held_count = cnt + 2'd1;
			end
		end

		if (grp.count != 2'd0) begin
			grp.res[grp.count - 2'd1].run_last = 1'b1;
		end
	end

endmodule

/* hdl/utf8sd_outbuf.sv */
// Result register: holds one byte's result group and hands it out one item at a time.
module utf8sd_outbuf import utf8sd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  group_t       grp,
	output logic         free,
	utf8sd_cp_if.source  cp_out
);

	group_t     grp_s2;
	logic       valid_s2;
	logic [1:0] ptr_q;
	logic       take;
	logic       last_take;
	res_t       cur;

	assign cur       = grp_s2.res[ptr_q];
	assign take      = valid_s2 & cp_out.ready;
	assign last_take = take & (ptr_q == grp_s2.count - 2'd1);
	assign free      = ~valid_s2 | last_take;

	assign cp_out.valid      = valid_s2;
	assign cp_out.char_value = cur.char_value;
	assign cp_out.valid_res  = cur.valid_res;
	assign cp_out.consumed   = cur.consumed;
	assign cp_out.run_last   = cur.run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ptr_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			ptr_q    <= '0;
		end else if (last_take) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s2 <= grp;
		end
	end

endmodule

/* hdl/utf8_stream_decoder_core.sv */
// Top level of the UTF-8 stream decoder: input register, decode, result register.
//
// byte_in takes one text byte per item, with end_of_text set on the last byte.
// cp_out gives result items: char_value, valid_res, consumed and run_last.
// run_last marks the final result caused by one input byte; a byte that only
// extends an open sequence gives no result at all.
// A byte accepted into the input register is decoded and, once the result
// register is free, lands in it, which offers its first result on cp_out.
// Throughput: one byte per cycle while cp_out is ready and each byte gives
// at most one result. An end-of-text byte that cuts a sequence short gives
// up to three results; the result register hands them out one per cycle
// while cp_out is ready, and the byte behind it waits in the input register
// until the last goes. When cp_out stalls, the result register holds, a byte
// that gives results waits in the input register, and byte_in.ready drops
// until the result group drains. Bytes that give no result pass through the
// input register even while the result register is full.
// Reset clears all valids and the sequence state: no sequence open, no bytes
// held. The next byte is taken as a fresh lead.
module utf8_stream_decoder_core import utf8sd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	utf8sd_byte_if.sink byte_in,
	utf8sd_cp_if.source cp_out
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// sequence state, updated when the input register item is retired
	state_t state_q;
	state_t state_next;
	group_t grp;

	logic free;
	logic move;
	logic load;

	utf8sd_decode u_decode (
		.st          (state_q),
		.in_byte     (byte_s1),
		.end_of_text (eot_s1),
		.grp         (grp),
		.st_next     (state_next)
	);

	// a result-free byte needs no room in the result register
	assign move = valid_s1 & ((grp.count == 2'd0) | free);
	assign load = valid_s1 & (grp.count != 2'd0) & free;

	assign byte_in.ready = ~valid_s1 | move;

	utf8sd_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.grp    (grp),
		.free   (free),
		.cp_out (cp_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.in_byte;
			eot_s1  <= byte_in.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (move) begin
			state_q <= state_next;
		end
	end

	// end of text always leaves the decoder with nothing open or held
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(move && eot_s1) |=> (state_q.seq_len == 3'd0 && state_q.held_count == 2'd0))
		else $error("sequence state not cleared after end of text");

	// an open sequence never holds as many bytes as its length
	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.seq_len != 3'd0) |-> ({1'b0, state_q.held_count} < state_q.seq_len))
		else $error("held byte count reached sequence length");

	// nothing is held while no sequence is open
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.seq_len == 3'd0) |-> (state_q.held_count == 2'd0))
		else $error("bytes held with no open sequence");

	// a byte in the input register that stalls keeps the decoder state
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !move) |=> $stable(state_q))
		else $error("decoder state changed during stall");

endmodule
